>>> rtl/core/servo_pulse_from_sample_defines.svh
// Assertion macros shared by the servo pulse generator.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef SERVO_PULSE_FROM_SAMPLE_DEFINES_SVH
`define SERVO_PULSE_FROM_SAMPLE_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SPFS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in servo pulse generator");

// Consequent must hold in the cycle after the antecedent.
`define SPFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in servo pulse generator");

`else

`define SPFS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SPFS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/spfs_pkg.sv
package spfs_pkg;

  localparam int COUNT_BITS_DEFAULT  = 13;
  localparam int SAMPLE_BITS_DEFAULT = 10;

  // Register reset values, truncated to the count width where they are used.
  localparam int MIN_WIDTH_RESET = 112;
  localparam int MAX_WIDTH_RESET = 600;
  localparam int PERIOD_RESET    = 5000;

  localparam int REG_INDEX_BITS = 2;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_MIN_WIDTH = 2'd0,
    REG_MAX_WIDTH = 2'd1,
    REG_PERIOD    = 2'd2
  } spfs_reg_t;

  // Control that travels with one mapped request into the pulse timer.
  typedef struct packed {
    logic step;          // the timer state advances this cycle
    logic sample_valid;  // the request carries a new width
    logic tick;          // one timer tick passes
  } spfs_ctrl_t;

endpackage

>>> rtl/core/spfs_width_map.sv
module spfs_width_map
  import spfs_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [COUNT_BITS-1:0]  min_width,
  input  logic [COUNT_BITS-1:0]  max_width,
  output logic [COUNT_BITS-1:0]  width
);

  logic [COUNT_BITS-1:0]             span;
  logic [SAMPLE_BITS+COUNT_BITS-1:0] product;
  logic [COUNT_BITS:0]               sum;

  always_comb begin
    // A maximum below the minimum gives no span, so the width is the minimum.
    span    = (max_width > min_width) ? (max_width - min_width) : '0;
    product = {{COUNT_BITS{1'b0}}, sample} * {{SAMPLE_BITS{1'b0}}, span};
    sum     = {1'b0, product[SAMPLE_BITS+COUNT_BITS-1:SAMPLE_BITS]} + {1'b0, min_width};
    width   = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  end

endmodule

>>> rtl/core/spfs_pulse_timer.sv
module spfs_pulse_timer
  import spfs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spfs_ctrl_t            ctrl,
  input  logic [COUNT_BITS-1:0] new_width,
  input  logic [COUNT_BITS-1:0] period,
  output logic                  pin_level,
  output logic [COUNT_BITS-1:0] active_width
);

  logic [COUNT_BITS-1:0] pending;
  logic [COUNT_BITS-1:0] pending_next;
  logic [COUNT_BITS-1:0] active;
  logic [COUNT_BITS-1:0] active_next;
  logic                  high;
  logic                  high_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] enter_width;
  logic [COUNT_BITS-1:0] low_len;

  always_comb begin
    pending_next = ctrl.sample_valid ? new_width : pending;
    enter_width  = (pending_next > period) ? period : pending_next;
    low_len      = (period > active) ? (period - active) : '0;
    active_next  = active;
    high_next    = high;
    count_next   = count;
    if (ctrl.tick) begin
      if (count > COUNT_BITS'(1)) begin
        count_next = count - COUNT_BITS'(1);
      end else if (!high || (low_len == '0)) begin
        // Start a new pulse; a zero width skips straight to a full low phase.
        active_next = enter_width;
        if (enter_width != '0) begin
          high_next  = 1'b1;
          count_next = enter_width;
        end else begin
          high_next  = 1'b0;
          count_next = period;
        end
      end else begin
        high_next  = 1'b0;
        count_next = low_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= COUNT_BITS'(MIN_WIDTH_RESET);
      active  <= COUNT_BITS'(MIN_WIDTH_RESET);
      high    <= 1'b0;
      count   <= '0;
    end else if (ctrl.step) begin
      pending <= pending_next;
      active  <= active_next;
      high    <= high_next;
      count   <= count_next;
    end
  end

  assign pin_level    = high;
  assign active_width = active;

endmodule

>>> rtl/core/servo_pulse_from_sample.sv
// A request is registered in the first stage, its result in the timer registers; the
// timer update is one compare and a count. One request per cycle while not stalled.
// The width multiply sits in its own stage ahead of the timer registers.
// Reset (synchronous, active high) empties the pipeline, loads the register defaults
// (min 112, max 600, period 5000) and leaves the pin low with the phase count at zero.
`include "servo_pulse_from_sample_defines.svh"

module servo_pulse_from_sample
  import spfs_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // Sample and tick requests.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      sample_valid,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic                      tick,
  // Pin state after each request.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      pin_level,
  output logic [COUNT_BITS-1:0]     active_width,
  // Register writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]     cfg_data
);

  // Configuration registers. Writes are always taken; an index past the list
  // is accepted and dropped.
  logic [COUNT_BITS-1:0] min_width;
  logic [COUNT_BITS-1:0] max_width;
  logic [COUNT_BITS-1:0] period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= COUNT_BITS'(MIN_WIDTH_RESET);
      max_width <= COUNT_BITS'(MAX_WIDTH_RESET);
      period    <= COUNT_BITS'(PERIOD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_WIDTH: min_width <= cfg_data;
        REG_MAX_WIDTH: max_width <= cfg_data;
        REG_PERIOD:    period    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Pipeline control. The timer registers double as the result register, so the
  // second stage moves only when the result slot is empty or being taken. The
  // first stage holds one more request while a result waits downstream.
  logic stage1_valid;
  logic out_full;
  logic stage2_enable;
  logic stage1_enable;
  logic in_accept;

  assign stage2_enable = !out_full || !out_stall;
  assign stage1_enable = !stage1_valid || stage2_enable;
  assign in_stall      = !stage1_enable;
  assign in_accept     = in_valid && stage1_enable;
  assign out_valid     = out_full;

  // The width is mapped from the sample on the way into the first stage. The
  // mapping does not depend on timer state, so it can run one stage early.
  logic [COUNT_BITS-1:0] mapped_width;
  logic [COUNT_BITS-1:0] stage1_width;
  logic                  stage1_sample_valid;
  logic                  stage1_tick;

  spfs_width_map #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_width_map (
    .sample    (sample),
    .min_width (min_width),
    .max_width (max_width),
    .width     (mapped_width)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      out_full     <= 1'b0;
    end else begin
      if (stage1_enable) begin
        stage1_valid <= in_valid;
      end
      if (stage2_enable) begin
        out_full <= stage1_valid;
      end
    end
  end

  // Payload of the first stage carries no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage1_width        <= mapped_width;
      stage1_sample_valid <= sample_valid;
      stage1_tick         <= tick;
    end
  end

  // The timer applies the new width first and then the tick, as one step.
  spfs_ctrl_t timer_ctrl;

  assign timer_ctrl.step         = stage1_valid && stage2_enable;
  assign timer_ctrl.sample_valid = stage1_sample_valid;
  assign timer_ctrl.tick         = stage1_tick;

  spfs_pulse_timer #(
    .COUNT_BITS (COUNT_BITS)
  ) u_pulse_timer (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (timer_ctrl),
    .new_width    (stage1_width),
    .period       (period),
    .pin_level    (pin_level),
    .active_width (active_width)
  );

  // A high pin always belongs to a pulse of nonzero width.
  `SPFS_ASSERT_SAME(a_high_has_width, clk, rst, pin_level, active_width != '0)
  // Requests are held off only when a result is waiting and stalled.
  `SPFS_ASSERT_SAME(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)
  // A result that is taken with nothing behind it leaves the output empty.
  `SPFS_ASSERT_NEXT(a_drain, clk, rst, out_valid && !out_stall && !stage1_valid, !out_valid)

endmodule

>>> tb/tb_servo_pulse_from_sample.sv
`timescale 1ns / 1ps

module tb_servo_pulse_from_sample;
  import spfs_pkg::*;

  localparam int CW = COUNT_BITS_DEFAULT;
  localparam int SW = SAMPLE_BITS_DEFAULT;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [SW-1:0] SMP_MAX = '1;
  // Edges waited after every result is back, as margin for the pipeline to settle.
  localparam int PIPE_DRAIN = 4;
  // Length of the one long receiver hold-off, and when it starts.
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AFTER = 700;

  // One request as it goes into the block.
  typedef struct packed {
    logic           sv;
    logic [SW-1:0]  smp;
    logic           tk;
  } servo_req_t;

  // Pin state that the block reports after each request.
  typedef struct packed {
    logic           pin;
    logic [CW-1:0]  width;
  } pulse_state_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           sample_valid = 1'b0;
  logic [SW-1:0]  sample = '0;
  logic           tick = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic           pin_level;
  logic [CW-1:0]  active_width;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [REG_INDEX_BITS-1:0] cfg_index = REG_MIN_WIDTH;
  logic [CW-1:0]  cfg_data = '0;

  servo_pulse_from_sample dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_valid (sample_valid),
    .sample       (sample),
    .tick         (tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pin_level    (pin_level),
    .active_width (active_width),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial forever #10 clk = ~clk;

  // Requests waiting to be offered, and pin states still owed by the block.
  servo_req_t   sample_tick_q[$];
  pulse_state_t pulse_due_q[$];

  int  queued_cnt = 0;
  int  accepted_cnt = 0;
  int  fail_cnt = 0;
  // When clear, neither side inserts gaps; this gives stretches at full rate.
  logic idle_on = 1'b0;
  // Set by its own process for one long stretch in which the receiver stalls.
  logic long_hold = 1'b0;

  // Our own copy of the registers and of the pulse timer state.
  logic [CW-1:0] cfg_min, cfg_max, cfg_period;
  logic [CW-1:0] pend_width, act_width, phase_left;
  logic          in_high;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Start a pulse: the pending width, clamped to the period, becomes the active
  // width. A zero width skips the high phase and starts a full low phase.
  function automatic void start_pulse();
    logic [CW-1:0] w;
    w = (pend_width > cfg_period) ? cfg_period : pend_width;
    act_width = w;
    if (w != '0) begin
      in_high = 1'b1;
      phase_left = w;
    end else begin
      in_high = 1'b0;
      phase_left = cfg_period;
    end
  endfunction

  // Apply one request to the timer copy and record the pin state it leads to.
  function automatic void servo_timer_step(servo_req_t r);
    logic [CW-1:0]    span, low_len;
    logic [SW+CW-1:0] prod;
    logic [CW+1:0]    w;
    pulse_state_t     st;
    if (r.sv) begin
      // A maximum below the minimum gives a span of zero.
      span = (cfg_max > cfg_min) ? cfg_max - cfg_min : '0;
      prod = r.smp * span;
      w = (CW + 2)'(prod >> SW) + cfg_min;
      pend_width = (w > CNT_MAX) ? CNT_MAX : w[CW-1:0];
    end
    if (r.tk) begin
      if (phase_left > 1) begin
        phase_left = phase_left - 1'b1;
      end else if (!in_high) begin
        start_pulse();
      end else begin
        // The low phase is whatever is left of the period; none left means
        // the next pulse begins on this same tick.
        low_len = (cfg_period > act_width) ? cfg_period - act_width : '0;
        if (low_len != '0) begin
          in_high = 1'b0;
          phase_left = low_len;
        end else begin
          start_pulse();
        end
      end
    end
    st.pin = in_high;
    st.width = act_width;
    pulse_due_q.push_back(st);
  endfunction

  // Sender. A request is taken at an edge with in_valid high and in_stall low;
  // the payload only moves on after that, or while nothing is offered.
  servo_req_t cur_req;
  int         tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        servo_timer_step(cur_req);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (sample_tick_q.size() != 0) begin
          cur_req = sample_tick_q.pop_front();
          sample_valid <= cur_req.sv;
          sample <= cur_req.smp;
          tick <= cur_req.tk;
          in_valid <= 1'b1;
          if (idle_on) tx_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls: random gaps of mostly short length, plus the long hold.
  int rx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
      if (idle_on) rx_gap = pick_gap();
    end
  end

  // Checker: every taken result is compared with the oldest owed pin state.
  always @(posedge clk) begin
    pulse_state_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pulse_due_q.size() == 0) begin
        note_failure($sformatf("result with no request pending: pin %0d width %0d",
                               pin_level, active_width));
      end else begin
        e = pulse_due_q.pop_front();
        if (pin_level !== e.pin || active_width !== e.width)
          note_failure($sformatf("pin %0d width %0d, wanted pin %0d width %0d",
                                 pin_level, active_width, e.pin, e.width));
      end
    end
  end

  // While the receiver holds off, the sender keeps offering requests, so the
  // pipeline fills and the block has to stall its input.
  initial begin
    wait (accepted_cnt >= LONG_HOLD_AFTER);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Register writes happen only with the block idle, so our copy can change
  // at the moment of the write without any ordering concern.
  task automatic write_reg(spfs_reg_t idx, logic [CW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_WIDTH: cfg_min = data;
      REG_MAX_WIDTH: cfg_max = data;
      REG_PERIOD:    cfg_period = data;
      default: ;
    endcase
  endtask

  task automatic push_req(logic sv, logic [SW-1:0] smp, logic tk);
    servo_req_t r;
    r.sv = sv;
    r.smp = smp;
    r.tk = tk;
    sample_tick_q.push_back(r);
    queued_cnt++;
  endtask

  // The sender pauses here until every request is taken and every pin state
  // has come back, then lets the pipeline settle.
  task automatic drain_results();
    while (accepted_cnt != queued_cnt || pulse_due_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // One setting of the registers followed by a run of random requests. The
  // sample leans toward both ends of its range now and then.
  task automatic run_phase(logic [CW-1:0] w_min, logic [CW-1:0] w_max,
                           logic [CW-1:0] per, int n, logic gaps);
    int            pick;
    logic [SW-1:0] smp;
    write_reg(REG_MIN_WIDTH, w_min);
    write_reg(REG_MAX_WIDTH, w_max);
    write_reg(REG_PERIOD, per);
    @(posedge clk);
    idle_on <= gaps;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) smp = '0;
      else if (pick == 1) smp = SMP_MAX;
      else smp = SW'($urandom);
      push_req($urandom_range(0, 99) < 35, smp, $urandom_range(0, 99) < 75);
    end
    drain_results();
  endtask

  initial begin
    cfg_min = CW'(MIN_WIDTH_RESET);
    cfg_max = CW'(MAX_WIDTH_RESET);
    cfg_period = CW'(PERIOD_RESET);
    pend_width = cfg_min;
    act_width = cfg_min;
    in_high = 1'b0;
    phase_left = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed requests on the reset registers: the reset state itself, both
    // ends of the sample, a sample without a tick and a tick without a sample,
    // and the very first tick ending the empty phase at once.
    push_req(1'b0, '0, 1'b0);
    push_req(1'b0, SMP_MAX, 1'b0);
    push_req(1'b1, SMP_MAX, 1'b0);
    push_req(1'b0, '0, 1'b1);
    push_req(1'b1, '0, 1'b1);
    push_req(1'b1, SMP_MAX, 1'b1);
    push_req(1'b1, SW'(512), 1'b0);
    push_req(1'b0, '0, 1'b1);
    push_req(1'b1, SW'(1), 1'b1);
    push_req(1'b1, SMP_MAX - 1'b1, 1'b1);
    push_req(1'b0, SMP_MAX, 1'b0);
    push_req(1'b1, '0, 1'b0);
    push_req(1'b0, SW'(512), 1'b1);
    drain_results();

    // Ordinary short period.
    run_phase(CW'(2), CW'(20), CW'(40), 130, 1'b1);
    // Zero width: the high phase is skipped and the pin stays low.
    run_phase('0, '0, CW'(10), 120, 1'b1);
    // Maximum below minimum, and a width above the period that clamps to it,
    // which leaves no low phase at all. No gaps here.
    run_phase(CW'(30), CW'(5), CW'(25), 120, 1'b0);
    // Full range of every register.
    run_phase('0, CNT_MAX, CNT_MAX, 120, 1'b1);
    // Period lowered below the width still active from before.
    run_phase(CNT_MAX, CNT_MAX, CW'(1), 120, 1'b1);
    // Zero period: the pin stays low and the count stays at zero.
    run_phase(CW'(3), CW'(12), '0, 120, 1'b0);
    run_phase(CW'(1), CW'(9), CW'(6), 130, 1'b1);
    // Width exactly equal to the period.
    run_phase(CW'(7), CW'(7), CW'(7), 120, 1'b1);
    repeat (5) begin
      run_phase(CW'($urandom_range(0, 40)), CW'($urandom_range(0, 60)),
                CW'($urandom_range(0, 70)), 120, 1'b1);
    end

    if (pulse_due_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", pulse_due_q.size()));
    if (fail_cnt == 0) begin
      $display("** servo_pulse_from_sample: PASSED **");
    end else begin
      $display("** servo_pulse_from_sample: FAILED **");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run with every gap at its longest.
  initial begin
    #20_000_000;
    $display("** servo_pulse_from_sample: FAILED **");
    $finish;
  end

endmodule
